@@ hdl/pfm_pkg.sv @@
`default_nettype none
package pfm_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_KEY_ON = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_GAIN    = 3'd0,
        CFG_OUTER   = 3'd1,
        CFG_INNER   = 3'd2,
        CFG_M1_STEP = 3'd3,
        CFG_M2_STEP = 3'd4,
        CFG_ATK     = 3'd5,
        CFG_DEC     = 3'd6,
        CFG_WAVE    = 3'd7
    } cfg_idx_t;

    localparam logic [31:0] LEVEL_ONE = 32'hFFFF_FFFF;
    localparam logic [31:0] SQ_LOW    = 32'hC000_0000;
    localparam logic [31:0] SQ_HIGH   = 32'h4000_0000;
    localparam logic [63:0] C1 = 64'd1686629713;
    localparam logic [63:0] C3 = 64'd693598668;
    localparam logic [63:0] C5 = 64'd85569306;
    localparam logic [63:0] C7 = 64'd5026995;
    localparam logic [63:0] C9 = 64'd172272;

    // Entry of the sine table, evaluated at elaboration
    function automatic logic signed [15:0] sine_entry(input int unsigned idx,
                                                     input int unsigned entries);
        logic [63:0] p;
        logic [1:0]  q;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        p  = (64'(idx) << 32) / 64'(entries);
        q  = p[31:30];
        x  = {34'd0, p[29:0]};
        if (q[0])
            x = 64'h4000_0000 - x;
        x2 = (x * x) >> 30;
        t  = C9;
        t  = C7 - ((x2 * t) >> 30);
        t  = C5 - ((x2 * t) >> 30);
        t  = C3 - ((x2 * t) >> 30);
        t  = C1 - ((x2 * t) >> 30);
        s  = (x * t) >> 30;
        s  = (s * 64'd32767 + 64'h2000_0000) >> 30;
        if (s > 64'd32767)
            s = 64'd32767;
        return q[1] ? -$signed(s[15:0]) : $signed(s[15:0]);
    endfunction

endpackage
`default_nettype wire

@@ hdl/pfm_sine_rom.sv @@
`default_nettype none
module pfm_sine_rom
    import pfm_pkg::*;
#(
    parameter int SINE_ENTRIES = 1024
)
(
    input  wire logic                clk,
    input  wire logic [31:0]         phase,
    output logic signed [15:0]       value
);
    localparam int AW = $clog2(SINE_ENTRIES);

    logic signed [15:0] rom [SINE_ENTRIES];
    logic [AW-1:0] addr;

    always_comb
    begin
        for (int i = 0; i < SINE_ENTRIES; i++)
        begin
            rom[i] = sine_entry(i, SINE_ENTRIES);
        end
    end

    assign addr = AW'((64'(phase) * 64'(SINE_ENTRIES)) >> 32);

    always_ff @(posedge clk)
    begin
        value <= rom[addr];
    end
endmodule
`default_nettype wire

@@ hdl/polyphonic_fm_voice_synth_top.sv @@
// Polyphonic three-operator FM voice synthesizer.
// Input channel (in_valid/in_stall): operation and carrier_step. A tick makes
// one sample on the output channel (out_valid/out_stall); key on and remove
// make no beat. Config port (cfg_valid/cfg_ready, cfg_index, cfg_data)
// writes registers 0..7 while the block is idle.
// One item at a time: in_stall is high from acceptance until the item is done.
// Key on appends a voice, after a steal shift of the list (one entry per
// cycle) when the list is full; remove drops the oldest voice by that shift.
// A tick walks the voices through one shared sine table and one shared 33x33
// multiplier: per sounding voice the sines of modulator 2, modulator 1 and
// carrier, the envelope and the mix (a silent one adds nothing), then per
// sounding voice the envelope and phase update, shifting out each voice
// whose decay level falls below DROP_THRESHOLD, and a saturated sample last.
// The sample waits in an output register; while out_stall is high the next
// item is still accepted and worked, and a new tick waits until the register
// is free. Reset clears the voice count, the registers to their defaults and
// the output valid; voice storage has no reset.
`default_nettype none
module polyphonic_fm_voice_synth_top
    import pfm_pkg::*;
#(
    parameter int          MAX_VOICES     = 8,
    parameter int          SINE_ENTRIES   = 1024,
    parameter logic [31:0] DROP_THRESHOLD = 32'd4294967
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         operation,
    input  wire logic [30:0]        carrier_step,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      sample,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    localparam int VW = $clog2(MAX_VOICES + 1);
    localparam int IW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SHIFT  = 11'b00000000010,
        S_APPEND = 11'b00000000100,
        S_V_SEL  = 11'b00000001000,
        S_SIN2   = 11'b00000010000,
        S_SIN1   = 11'b00000100000,
        S_SIN0   = 11'b00001000000,
        S_ENV    = 11'b00010000000,
        S_MIX    = 11'b00100000000,
        S_UPD    = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [14:0] gain_reg;
    logic [23:0] outer_reg, inner_reg;
    logic [30:0] m1_step_reg, m2_step_reg;
    logic [31:0] atk_rate_reg, dec_rate_reg;
    logic [2:0]  wave_reg;

    logic [31:0] car_ph [MAX_VOICES];
    logic [31:0] car_in [MAX_VOICES];
    logic [31:0] m1_ph  [MAX_VOICES];
    logic [31:0] m2_ph  [MAX_VOICES];
    logic [31:0] m1_in  [MAX_VOICES];
    logic [31:0] m2_in  [MAX_VOICES];
    logic [31:0] atk_m  [MAX_VOICES];
    logic [31:0] dec_m  [MAX_VOICES];
    logic [31:0] atk_l  [MAX_VOICES];
    logic [31:0] dec_l  [MAX_VOICES];

    logic [VW-1:0] count_reg;
    logic [VW-1:0] vidx_reg;
    logic [VW-1:0] sidx_reg;
    logic          upd_pass_reg;
    logic          key_on_reg;
    logic [1:0]    sub_reg;
    logic [30:0]   step_reg;
    logic signed [63:0] sum_reg;
    logic [31:0]   arg_reg;
    logic [31:0]   env_reg;
    logic signed [31:0] gs_reg;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_full;
    logic [63:0]   prod;
    logic signed [15:0] sin_val;
    logic          out_valid_reg;
    logic signed [15:0] sample_reg;
    logic [IW-1:0] vi, si;

    assign vi = vidx_reg[IW-1:0];
    assign si = sidx_reg[IW-1:0];

    pfm_sine_rom #(.SINE_ENTRIES(SINE_ENTRIES)) u_rom (
        .clk   (clk),
        .phase (arg_reg),
        .value (sin_val)
    );

    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && operation == OP_TICK);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    function automatic logic [31:0] shape(input logic [31:0] ph, input logic sq);
        if (!sq)
            return ph;
        return ph[31] ? SQ_HIGH : SQ_LOW;
    endfunction

    assign prod_full = mul_a * mul_b;
    assign prod      = prod_full[63:0];

    logic signed [63:0] sat_q;
    assign sat_q = sum_reg >>> 31;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            gain_reg      <= 15'd8192;
            outer_reg     <= '0;
            inner_reg     <= '0;
            m1_step_reg   <= '0;
            m2_step_reg   <= '0;
            atk_rate_reg  <= 32'd4294855449;
            dec_rate_reg  <= 32'd4294855449;
            wave_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_GAIN:    gain_reg     <= cfg_data[14:0];
                    CFG_OUTER:   outer_reg    <= cfg_data[23:0];
                    CFG_INNER:   inner_reg    <= cfg_data[23:0];
                    CFG_M1_STEP: m1_step_reg  <= cfg_data[30:0];
                    CFG_M2_STEP: m2_step_reg  <= cfg_data[30:0];
                    CFG_ATK:     atk_rate_reg <= cfg_data;
                    CFG_DEC:     dec_rate_reg <= cfg_data;
                    CFG_WAVE:    wave_reg     <= cfg_data[2:0];
                    default:     ;
                endcase
            end
            case (state_reg)
                S_SHIFT:
                begin
                    if (sidx_reg + VW'(1) >= count_reg)
                        count_reg <= count_reg - VW'(1);
                end
                S_APPEND: count_reg <= count_reg + VW'(1);
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    if (sat_q > 64'sd32767)
                        sample_reg <= 16'sh7FFF;
                    else if (sat_q < -64'sd32768)
                        sample_reg <= -16'sh8000;
                    else
                        sample_reg <= sat_q[15:0];
                end
                default: ;
            endcase
        end
    end

    // Datapath: one multiplier, one sine table, list shift one entry per cycle
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                step_reg     <= carrier_step;
                key_on_reg   <= (operation == OP_KEY_ON);
                sum_reg      <= '0;
                vidx_reg     <= '0;
                sidx_reg     <= '0;
                sub_reg      <= '0;
                upd_pass_reg <= 1'b0;
            end
            S_SHIFT:
            begin
                if (sidx_reg + VW'(1) < count_reg)
                begin
                    car_ph[si] <= car_ph[si+IW'(1)];
                    car_in[si] <= car_in[si+IW'(1)];
                    m1_ph[si]  <= m1_ph[si+IW'(1)];
                    m2_ph[si]  <= m2_ph[si+IW'(1)];
                    m1_in[si]  <= m1_in[si+IW'(1)];
                    m2_in[si]  <= m2_in[si+IW'(1)];
                    atk_m[si]  <= atk_m[si+IW'(1)];
                    dec_m[si]  <= dec_m[si+IW'(1)];
                    atk_l[si]  <= atk_l[si+IW'(1)];
                    dec_l[si]  <= dec_l[si+IW'(1)];
                end
                sidx_reg <= sidx_reg + VW'(1);
            end
            S_APPEND:
            begin
                car_ph[count_reg[IW-1:0]] <= '0;
                m1_ph[count_reg[IW-1:0]]  <= '0;
                m2_ph[count_reg[IW-1:0]]  <= '0;
                car_in[count_reg[IW-1:0]] <= {1'b0, step_reg};
                m1_in[count_reg[IW-1:0]]  <= {1'b0, m1_step_reg};
                m2_in[count_reg[IW-1:0]]  <= {1'b0, m2_step_reg};
                atk_m[count_reg[IW-1:0]]  <= atk_rate_reg;
                dec_m[count_reg[IW-1:0]]  <= dec_rate_reg;
                atk_l[count_reg[IW-1:0]]  <= LEVEL_ONE;
                dec_l[count_reg[IW-1:0]]  <= LEVEL_ONE;
            end
            S_V_SEL:
            begin
                sub_reg <= '0;
                if (upd_pass_reg)
                begin
                    sidx_reg <= vidx_reg;
                    if (vidx_reg < count_reg && car_in[vi] == '0)
                        vidx_reg <= vidx_reg + VW'(1);
                end
                else
                    arg_reg <= shape(m2_ph[vi], wave_reg[2]);
            end
            S_SIN2:
            begin
                sub_reg <= sub_reg + 2'd1;
                if (sub_reg == 2'd1)
                    arg_reg <= shape(m1_ph[vi], wave_reg[1])
                             + 32'(prod << 1);
            end
            S_SIN1:
            begin
                sub_reg <= sub_reg + 2'd1;
                if (sub_reg == 2'd1)
                    arg_reg <= shape(car_ph[vi], wave_reg[0])
                             + 32'(prod << 1);
            end
            S_SIN0:
            begin
                sub_reg <= sub_reg + 2'd1;
                if (sub_reg == 2'd1)
                    gs_reg <= 32'(prod);
            end
            S_ENV:
            begin
                env_reg <= prod[63:32];
            end
            S_MIX:
            begin
                if (car_in[vi] != '0)
                    sum_reg <= sum_reg + $signed(prod);
                if (vidx_reg + VW'(1) >= count_reg)
                begin
                    upd_pass_reg <= 1'b1;
                    vidx_reg     <= '0;
                end
                else
                    vidx_reg <= vidx_reg + VW'(1);
            end
            S_UPD:
            begin
                sub_reg <= sub_reg + 2'd1;
                if (sub_reg == 2'd0)
                    atk_l[vi] <= prod[63:32];
                else
                begin
                    dec_l[vi]  <= prod[63:32];
                    car_ph[vi] <= car_ph[vi] + car_in[vi];
                    m1_ph[vi]  <= m1_ph[vi] + m1_in[vi];
                    m2_ph[vi]  <= m2_ph[vi] + m2_in[vi];
                    if (prod[63:32] >= DROP_THRESHOLD)
                        vidx_reg <= vidx_reg + VW'(1);
                end
            end
            default: ;
        endcase
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SIN2:
            begin
                mul_a = 33'(signed'({1'b0, inner_reg}));
                mul_b = 33'(sin_val);
            end
            S_SIN1:
            begin
                mul_a = 33'(signed'({1'b0, outer_reg}));
                mul_b = 33'(sin_val);
            end
            S_SIN0:
            begin
                mul_a = 33'(signed'({1'b0, gain_reg}));
                mul_b = 33'(sin_val);
            end
            S_ENV:
            begin
                mul_a = {1'b0, LEVEL_ONE - atk_l[vi]};
                mul_b = {1'b0, dec_l[vi]};
            end
            S_MIX:
            begin
                mul_a = 33'(gs_reg);
                mul_b = {17'd0, env_reg[31:16]};
            end
            S_UPD:
            begin
                if (sub_reg == 2'd0)
                begin
                    mul_a = {1'b0, atk_l[vi]};
                    mul_b = {1'b0, atk_m[vi]};
                end
                else
                begin
                    mul_a = {1'b0, dec_l[vi]};
                    mul_b = {1'b0, dec_m[vi]};
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    case (op_t'(operation))
                        OP_TICK:
                            state_next = (count_reg == '0) ? S_DONE : S_V_SEL;
                        OP_KEY_ON:
                            state_next = (count_reg >= VW'(MAX_VOICES)) ? S_SHIFT : S_APPEND;
                        OP_REMOVE:
                            state_next = (count_reg == '0) ? S_IDLE : S_SHIFT;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_SHIFT:
            begin
                if (sidx_reg + VW'(1) >= count_reg)
                begin
                    if (upd_pass_reg)
                        state_next = S_V_SEL;
                    else if (key_on_reg)
                        state_next = S_APPEND;
                    else
                        state_next = S_IDLE;
                end
            end
            S_APPEND: state_next = S_IDLE;
            S_V_SEL:
            begin
                if (vidx_reg >= count_reg)
                    state_next = upd_pass_reg ? S_DONE : S_UPD;
                else if (car_in[vi] == '0)
                    state_next = upd_pass_reg ? S_V_SEL : S_MIX;
                else
                    state_next = upd_pass_reg ? S_UPD : S_SIN2;
            end
            S_SIN2: if (sub_reg == 2'd1) state_next = S_SIN1;
            S_SIN1: if (sub_reg == 2'd1) state_next = S_SIN0;
            S_SIN0: if (sub_reg == 2'd1) state_next = S_ENV;
            S_ENV:  state_next = S_MIX;
            S_MIX:  state_next = S_V_SEL;
            S_UPD:
            begin
                if (sub_reg != 2'd0)
                    state_next = (prod[63:32] < DROP_THRESHOLD) ? S_SHIFT : S_V_SEL;
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ hdl/pfm_checker.sv @@
`default_nettype none
module pfm_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic [15:0] sample,
    input wire logic cfg_ready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample))
        else $error("output beat dropped while stalled");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> cfg_ready)
        else $error("input taken while busy");
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_ready |-> in_stall)
        else $error("input open while busy");
endmodule

bind polyphonic_fm_voice_synth_top pfm_checker u_pfm_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sample(sample),
    .cfg_ready(cfg_ready)
);
`default_nettype wire

@@ tb/sv/fm_synth_checker.sv @@
module fm_synth_checker
    import pfm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [1:0]         operation,
    input  wire logic [30:0]        carrier_step,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic signed [15:0] sample,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output int                      fail_count,
    output int                      pending_samples
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VOICES = 8;
    localparam int TABLE_LEN = 1024;
    localparam logic [31:0] CUTOFF_LEVEL = 32'd4294967;

    typedef struct {
        logic [31:0] car_ph, m1_ph, m2_ph;
        logic [31:0] car_inc, m1_inc, m2_inc;
        logic [31:0] atk_mul, dec_mul, atk_lvl, dec_lvl;
    } voice_t;

    logic [14:0] gain;
    logic [23:0] outer_depth, inner_depth;
    logic [30:0] m1_step_reg, m2_step_reg;
    logic [31:0] atk_rate, dec_rate;
    logic [2:0]  waves;
    voice_t      voices[$];
    logic signed [15:0] sine_tab[TABLE_LEN];
    logic signed [15:0] expected_samples[$];

    function automatic logic signed [15:0] poly_sine(int unsigned idx);
        logic [63:0] p, x, x2, t, s;
        p = ({32'd0, idx} << 32) / TABLE_LEN;
        x = {34'd0, p[29:0]};
        if (p[30])
            x = 64'h4000_0000 - x;
        x2 = (x * x) >> 30;
        t = 64'd172272;
        t = 64'd5026995 - ((x2 * t) >> 30);
        t = 64'd85569306 - ((x2 * t) >> 30);
        t = 64'd693598668 - ((x2 * t) >> 30);
        t = 64'd1686629713 - ((x2 * t) >> 30);
        s = (x * t) >> 30;
        s = (s * 64'd32767 + 64'h2000_0000) >> 30;
        if (s > 64'd32767)
            s = 64'd32767;
        return p[31] ? -$signed(s[15:0]) : $signed(s[15:0]);
    endfunction

    function automatic logic signed [15:0] lookup(logic [31:0] ph);
        logic [63:0] i;
        i = ({32'd0, ph} * TABLE_LEN) >> 32;
        return sine_tab[i];
    endfunction

    function automatic logic [31:0] shaped(logic [31:0] ph, logic sq);
        if (!sq)
            return ph;
        return ph[31] ? SQ_HIGH : SQ_LOW;
    endfunction

    function automatic logic [31:0] mod_turns(logic [23:0] depth, logic signed [15:0] s);
        logic signed [63:0] prod;
        prod = $signed({40'd0, depth}) * 64'(s);
        return prod[31:0] << 1;
    endfunction

    function automatic logic [31:0] level_scale(logic [31:0] lvl, logic [31:0] mul);
        logic [63:0] p;
        p = {32'd0, lvl} * {32'd0, mul};
        return p[63:32];
    endfunction

    function automatic logic signed [15:0] mix_sample();
        logic signed [63:0] acc, smp;
        logic [31:0] a0, a1, a2, att;
        logic [63:0] env;
        logic signed [15:0] s;
        int n;
        acc = 0;
        foreach (voices[k])
        begin
            if (voices[k].car_inc == 0)
                continue;
            a2 = shaped(voices[k].m2_ph, waves[2]);
            a1 = shaped(voices[k].m1_ph, waves[1]) + mod_turns(inner_depth, lookup(a2));
            a0 = shaped(voices[k].car_ph, waves[0]) + mod_turns(outer_depth, lookup(a1));
            s = lookup(a0);
            att = LEVEL_ONE - voices[k].atk_lvl;
            env = ({32'd0, att} * {32'd0, voices[k].dec_lvl}) >> 32;
            acc += (64'(gain) * 64'(s)) * $signed(env >> 16);
        end
        n = 0;
        while (n < voices.size())
        begin
            if (voices[n].car_inc != 0)
            begin
                voices[n].car_ph += voices[n].car_inc;
                voices[n].m1_ph += voices[n].m1_inc;
                voices[n].m2_ph += voices[n].m2_inc;
                voices[n].atk_lvl = level_scale(voices[n].atk_lvl, voices[n].atk_mul);
                voices[n].dec_lvl = level_scale(voices[n].dec_lvl, voices[n].dec_mul);
                if (voices[n].dec_lvl < CUTOFF_LEVEL)
                begin
                    voices.delete(n);
                    continue;
                end
            end
            n++;
        end
        smp = acc >>> 31;
        if (smp > 32767)
            smp = 32767;
        if (smp < -32768)
            smp = -32768;
        return smp[15:0];
    endfunction

    task automatic report(string what, logic signed [15:0] got, logic signed [15:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_LEN; i++)
            sine_tab[i] = poly_sine(i);
        fail_count = 0;
    end

    assign pending_samples = expected_samples.size();

    always @(posedge clk or negedge rst_n)
    begin
        voice_t v;
        if (!rst_n)
        begin
            gain <= 15'd8192;
            outer_depth <= '0;
            inner_depth <= '0;
            m1_step_reg <= '0;
            m2_step_reg <= '0;
            atk_rate <= 32'd4294855449;
            dec_rate <= 32'd4294855449;
            waves <= '0;
            voices.delete();
            expected_samples.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                    report("unexpected beat", sample, 16'sd0);
                else if (sample !== expected_samples[0])
                    report("sample", sample, expected_samples[0]);
                if (expected_samples.size() != 0)
                    void'(expected_samples.pop_front());
            end
            if (in_valid && !in_stall)
            begin
                case (op_t'(operation))
                    OP_TICK:
                        expected_samples.push_back(mix_sample());
                    OP_KEY_ON:
                    begin
                        if (voices.size() >= VOICES)
                            voices.delete(0);
                        v.car_ph = 0;
                        v.m1_ph = 0;
                        v.m2_ph = 0;
                        v.car_inc = {1'b0, carrier_step};
                        v.m1_inc = {1'b0, m1_step_reg};
                        v.m2_inc = {1'b0, m2_step_reg};
                        v.atk_mul = atk_rate;
                        v.dec_mul = dec_rate;
                        v.atk_lvl = LEVEL_ONE;
                        v.dec_lvl = LEVEL_ONE;
                        voices.push_back(v);
                    end
                    OP_REMOVE:
                        if (voices.size() != 0)
                            voices.delete(0);
                    default: ;
                endcase
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_GAIN:    gain <= cfg_data[14:0];
                    CFG_OUTER:   outer_depth <= cfg_data[23:0];
                    CFG_INNER:   inner_depth <= cfg_data[23:0];
                    CFG_M1_STEP: m1_step_reg <= cfg_data[30:0];
                    CFG_M2_STEP: m2_step_reg <= cfg_data[30:0];
                    CFG_ATK:     atk_rate <= cfg_data;
                    CFG_DEC:     dec_rate <= cfg_data;
                    CFG_WAVE:    waves <= cfg_data[2:0];
                    default:     ;
                endcase
            end
        end
    end
endmodule

@@ tb/sv/testbench.sv @@
module testbench;
    import pfm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         operation = OP_TICK;
    logic [30:0]        carrier_step = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] sample;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = CFG_GAIN;
    logic [31:0]        cfg_data = '0;
    int                 fail_count;
    int                 pending_samples;
    int                 cycles = 0;
    int                 hold_off = 0;
    bit                 stall_random = 1'b0;

    polyphonic_fm_voice_synth_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .carrier_step(carrier_step),
        .out_valid(out_valid), .out_stall(out_stall), .sample(sample),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    fm_synth_checker checker_inst (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .carrier_step(carrier_step),
        .out_valid(out_valid), .out_stall(out_stall), .sample(sample),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_samples(pending_samples)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stall pattern, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else if (stall_random)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= 1'b0;
    end

    task automatic send(op_t op, logic [30:0] step);
        in_valid <= 1'b1;
        operation <= op;
        carrier_step <= step;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic pause(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_samples != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [30:0] rand_step();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom_range(1, 1 << 20));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic random_phase(int count);
        int burst;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3:  send(OP_KEY_ON, rand_step());
                    4:           send(OP_REMOVE, 31'($urandom));
                    5:           send(OP_NONE, 31'($urandom));
                    default:     send(OP_TICK, 31'($urandom));
                endcase
                sent++;
            end
            if ($urandom_range(0, 2) == 0)
                pause($urandom_range(1, 30));
        end
    endtask

    task automatic random_config();
        write_reg(CFG_GAIN, $urandom_range(0, 2) == 0 ? 32'h7FFF : 32'($urandom_range(0, 32767)));
        write_reg(CFG_OUTER, $urandom_range(0, 3) == 0 ? 32'hFF_FFFF : 32'($urandom) & 32'hFF_FFFF);
        write_reg(CFG_INNER, $urandom_range(0, 3) == 0 ? 32'h0 : 32'($urandom) & 32'hFF_FFFF);
        write_reg(CFG_M1_STEP, $urandom);
        write_reg(CFG_M2_STEP, $urandom);
        write_reg(CFG_ATK, $urandom_range(0, 1) ? 32'hFFF0_0000 | $urandom : $urandom);
        write_reg(CFG_DEC, $urandom_range(0, 1) ? 32'hFFFF_0000 | $urandom : $urandom);
        write_reg(CFG_WAVE, $urandom_range(0, 7));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, extremes, steal, removal on empty, silent voice
        send(OP_TICK, '0);
        send(OP_REMOVE, '0);
        send(OP_NONE, 31'h7FFF_FFFF);
        send(OP_KEY_ON, '0);
        send(OP_TICK, '0);
        repeat (9)
            send(OP_KEY_ON, 31'h7FFF_FFFF);
        send(OP_TICK, '0);
        send(OP_TICK, '0);
        send(OP_REMOVE, '0);
        send(OP_TICK, '0);
        drain();
        write_reg(CFG_GAIN, 32'h7FFF);
        write_reg(CFG_OUTER, 32'hFF_FFFF);
        write_reg(CFG_INNER, 32'hFF_FFFF);
        write_reg(CFG_M1_STEP, 32'h7FFF_FFFF);
        write_reg(CFG_M2_STEP, 32'h1234_5678);
        write_reg(CFG_ATK, 32'h0);
        write_reg(CFG_DEC, 32'hFFFF_FFFF);
        write_reg(CFG_WAVE, 32'h7);
        repeat (8)
            send(OP_KEY_ON, 31'h4000_0000);
        send(OP_TICK, '0);
        send(OP_TICK, '0);
        drain();
        write_reg(CFG_DEC, 32'h0);
        send(OP_KEY_ON, 31'd1);
        send(OP_TICK, '0);
        send(OP_TICK, '0);
        drain();

        stall_random = 1'b1;
        for (int ph = 0; ph < 8; ph++)
        begin
            random_config();
            random_phase(200);
            if (ph == 3)
            begin
                hold_off = 400;
                random_phase(20);
            end
            drain();
        end
        write_reg(CFG_GAIN, 32'h0);
        write_reg(CFG_DEC, 32'hFFFF_FFFF);
        random_phase(30);
        drain();

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
